/* hw/rtl/vrbm_pkg.sv */
// Shared types, constants and helpers for the vector ring buffer magnitude block.
`default_nettype none

package vrbm_pkg;

    // Ring geometry
    localparam int DEPTH = 64;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    // Field widths
    localparam int TS_W      = 64;
    localparam int RAW_W     = 16;
    localparam int AXIS_W    = 26;
    localparam int MAG_W     = 26;
    localparam int OUT_CNT_W = 7;

    // Scaling by 0.01 with 16 fraction bits: (|raw| * 2^16 + 50) / 100
    localparam int FRAC_W     = 16;
    localparam int ROUND_BIAS = 50;
    localparam int SCALE_DIV  = 100;
    localparam int NUM_W      = RAW_W + FRAC_W;
    localparam int QUO_W      = AXIS_W - 1;
    localparam int DREM_W     = $clog2(SCALE_DIV);
    localparam int DSTEP_W    = $clog2(NUM_W);

    // Magnitude: serial sum of squares, then two radicand bits per root step
    localparam int ABS_W    = AXIS_W - 1;
    localparam int SUM_W    = 2 * ABS_W + 2;
    localparam int SQ_STEPS = ABS_W;
    localparam int RT_STEPS = SUM_W / 2;
    localparam int RREM_W   = MAG_W + 2;
    localparam int MSTEP_W  = $clog2(RT_STEPS);

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [CNT_W-1:0] cnt_t;

    typedef enum logic [1:0] {
        CMD_PUSH  = 2'd0,
        CMD_FLUSH = 2'd1,
        CMD_COUNT = 2'd2
    } cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCALE,
        ST_READ,
        ST_LOAD,
        ST_ROOT
    } state_t;

    typedef enum logic [1:0] {
        MAG_IDLE,
        MAG_SQUARE,
        MAG_ROOT
    } mag_state_t;

    typedef struct packed {
        logic signed [TS_W-1:0]   ts;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
    } entry_t;

    typedef struct packed {
        logic   en;
        ptr_t   addr;
        entry_t data;
    } ring_wr_t;

    typedef struct packed {
        logic en;
        ptr_t addr;
    } ring_rd_t;

    function automatic ptr_t ptr_inc(input ptr_t p);
        ptr_t r;
        if (p == PTR_W'(DEPTH - 1))
            r = '0;
        else
            r = p + PTR_W'(1);
        return r;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/vector_ring_buffer_magnitude_top.sv */
// Top level: command sequencer, ring pointers and result register.
//
//  channel  | signals                                           | handshake
//  ---------+---------------------------------------------------+---------------------------
//  config   | cfg_write, cfg_data                               | written when cfg_write high
//  command  | command, timestamp, raw_x, raw_y, raw_z           | beat when start && !busy
//  result   | kind, out_timestamp, pos_x/y/z, magnitude,        | beat on the strobe cycle
//           | available_count, last                             |
//
// Push: busy after the beat until the 32-step bit-serial divide by 100 has finished.
// Count: never busy; the reply beat comes in the cycle after the command beat.
// Flush: per stored entry, one memory read, then the 25-step serial sum of squares and
// the 26-step root. last marks the final beat.
// Reset clears pointers, occupancy and the consumer flag; storage is not cleared.
// Result beats are held one cycle only; the receiver cannot stall.
`default_nettype none

module vector_ring_buffer_magnitude_top
    import vrbm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_write,
    input  wire logic                      cfg_data,
    input  wire logic                      start,
    output logic                           busy,
    input  wire logic [1:0]                command,
    input  wire logic signed [TS_W-1:0]    timestamp,
    input  wire logic signed [RAW_W-1:0]   raw_x,
    input  wire logic signed [RAW_W-1:0]   raw_y,
    input  wire logic signed [RAW_W-1:0]   raw_z,
    output logic                           strobe,
    output logic                           kind,
    output logic signed [TS_W-1:0]         out_timestamp,
    output logic signed [AXIS_W-1:0]       pos_x,
    output logic signed [AXIS_W-1:0]       pos_y,
    output logic signed [AXIS_W-1:0]       pos_z,
    output logic [MAG_W-1:0]               magnitude,
    output logic [OUT_CNT_W-1:0]           available_count,
    output logic                           last
);

    state_t   state_reg;
    state_t   state_next;
    ptr_t     wp_reg;
    ptr_t     rp_reg;
    cnt_t     occ_reg;
    cnt_t     left_reg;
    cnt_t     held_reg;
    logic     consumer_reg;
    logic     strobe_reg;

    logic signed [TS_W-1:0]   ts_reg;
    logic                     kind_reg;
    logic signed [TS_W-1:0]   out_ts_reg;
    logic signed [AXIS_W-1:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [MAG_W-1:0]         mag_reg;
    logic [OUT_CNT_W-1:0]     count_reg;
    logic                     last_reg;

    cmd_t     cmd;
    logic     accept;
    logic     scale_start;
    logic     flush_go;
    logic     reply;
    logic     emit;
    logic     mag_start;
    ring_wr_t ring_wr;
    ring_rd_t ring_rd;
    entry_t   rdata;
    ptr_t     rd_base;
    logic [CNT_W:0] rd_sum;

    logic signed [AXIS_W-1:0] code_x, code_y, code_z;
    logic     done_x, done_y, done_z;
    logic [MAG_W-1:0] mag_val;
    logic     mag_done;

    assign cmd = cmd_t'(command);

    vrbm_scale u_scale_x (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .raw   (raw_x),
        .code  (code_x),
        .done  (done_x)
    );

    vrbm_scale u_scale_y (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .raw   (raw_y),
        .code  (code_y),
        .done  (done_y)
    );

    vrbm_scale u_scale_z (
        .clk   (clk),
        .rst_n (rst_n),
        .start (scale_start),
        .raw   (raw_z),
        .code  (code_z),
        .done  (done_z)
    );

    vrbm_ring u_ring (
        .clk   (clk),
        .wr    (ring_wr),
        .rd    (ring_rd),
        .rdata (rdata)
    );

    vrbm_mag u_mag (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (mag_start),
        .x         (rdata.x),
        .y         (rdata.y),
        .z         (rdata.z),
        .magnitude (mag_val),
        .done      (mag_done)
    );

    // oldest entry sits occupancy places behind the write pointer
    always_comb
    begin
        rd_sum = (CNT_W+1)'(wp_reg) + (CNT_W+1)'(DEPTH) - (CNT_W+1)'(occ_reg);
        if (rd_sum >= (CNT_W+1)'(DEPTH))
            rd_sum = rd_sum - (CNT_W+1)'(DEPTH);
        rd_base = PTR_W'(rd_sum);
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    unique case (cmd)
                        CMD_PUSH:  state_next = ST_SCALE;
                        CMD_FLUSH:
                            if (consumer_reg && occ_reg != '0)
                                state_next = ST_READ;
                        CMD_COUNT: state_next = ST_IDLE;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_SCALE: if (done_x) state_next = ST_IDLE;
            ST_READ:  state_next = ST_LOAD;
            ST_LOAD:  state_next = ST_ROOT;
            ST_ROOT:
                if (mag_done)
                    state_next = (left_reg == CNT_W'(1)) ? ST_IDLE : ST_READ;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        accept       = start && (state_reg == ST_IDLE);
        scale_start  = accept && (cmd == CMD_PUSH);
        flush_go     = accept && (cmd == CMD_FLUSH) && consumer_reg && (occ_reg != '0);
        reply        = accept && (cmd == CMD_COUNT);
        emit         = (state_reg == ST_ROOT) && mag_done;
        mag_start    = (state_reg == ST_LOAD);
        ring_wr.en   = (state_reg == ST_SCALE) && done_x;
        ring_wr.addr = wp_reg;
        ring_wr.data = '{ts: ts_reg, x: code_x, y: code_y, z: code_z};
        ring_rd.en   = (state_reg == ST_READ);
        ring_rd.addr = rp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            wp_reg       <= '0;
            rp_reg       <= '0;
            occ_reg      <= '0;
            left_reg     <= '0;
            consumer_reg <= 1'b0;
            strobe_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= reply || emit;
            if (cfg_write)
                consumer_reg <= cfg_data;
            if (ring_wr.en)
            begin
                wp_reg <= ptr_inc(wp_reg);
                if (occ_reg != CNT_W'(DEPTH))
                    occ_reg <= occ_reg + CNT_W'(1);
            end
            if (flush_go)
            begin
                occ_reg  <= '0;
                rp_reg   <= rd_base;
                left_reg <= occ_reg;
            end
            if (emit)
            begin
                rp_reg   <= ptr_inc(rp_reg);
                left_reg <= left_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scale_start)
            ts_reg <= timestamp;
        if (flush_go)
            held_reg <= occ_reg;
        if (reply)
        begin
            kind_reg   <= 1'b1;
            out_ts_reg <= '0;
            pos_x_reg  <= '0;
            pos_y_reg  <= '0;
            pos_z_reg  <= '0;
            mag_reg    <= '0;
            count_reg  <= OUT_CNT_W'(occ_reg);
            last_reg   <= 1'b1;
        end
        else if (emit)
        begin
            kind_reg   <= 1'b0;
            out_ts_reg <= rdata.ts;
            pos_x_reg  <= rdata.x;
            pos_y_reg  <= rdata.y;
            pos_z_reg  <= rdata.z;
            mag_reg    <= mag_val;
            count_reg  <= OUT_CNT_W'(held_reg);
            last_reg   <= (left_reg == CNT_W'(1));
        end
    end

    assign busy            = (state_reg != ST_IDLE);
    assign strobe          = strobe_reg;
    assign kind            = kind_reg;
    assign out_timestamp   = out_ts_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign pos_z           = pos_z_reg;
    assign magnitude       = mag_reg;
    assign available_count = count_reg;
    assign last            = last_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(DEPTH))
        else $error("occupancy above ring depth");

    a_flush_needs_consumer: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |-> consumer_reg && (left_reg != '0))
        else $error("flush read without consumer or entries");

    a_last_ends_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe_reg && last_reg && !kind_reg) |-> (state_reg == ST_IDLE) && (occ_reg == '0))
        else $error("final flush beat while flush still running");

    a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
        ring_wr.en |=> (occ_reg != '0) && (wp_reg == ptr_inc($past(wp_reg))))
        else $error("push did not advance ring");

    a_scale_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
        (done_y == done_x) && (done_z == done_x))
        else $error("axis dividers out of step");

endmodule

`default_nettype wire

/* hw/rtl/vrbm_scale.sv */
// Bit-serial divide by 100 that scales one raw axis into 16-fraction-bit fixed point.
`default_nettype none

module vrbm_scale
    import vrbm_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic signed [RAW_W-1:0]  raw,
    output logic signed [AXIS_W-1:0]      code,
    output logic                          done
);

    logic                  run_reg;
    logic                  done_reg;
    logic [DSTEP_W-1:0]    cnt_reg;
    logic [NUM_W-1:0]      num_reg;
    logic [DREM_W-1:0]     rem_reg;
    logic [QUO_W-1:0]      quo_reg;
    logic                  neg_reg;

    logic [RAW_W-1:0]      raw_abs;
    logic [DREM_W:0]       rem_sh;
    logic                  ge;
    logic [DREM_W-1:0]     rem_next;

    // -32768 negates to the bit pattern of +32768, which is what we want unsigned
    assign raw_abs = raw[RAW_W-1] ? RAW_W'(-raw) : RAW_W'(raw);

    always_comb
    begin
        rem_sh   = {rem_reg, num_reg[NUM_W-1]};
        ge       = (rem_sh >= (DREM_W+1)'(SCALE_DIV));
        rem_next = ge ? DREM_W'(rem_sh - (DREM_W+1)'(SCALE_DIV)) : DREM_W'(rem_sh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && !start && (cnt_reg == DSTEP_W'(NUM_W - 1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= '0;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg + DSTEP_W'(1);
                if (cnt_reg == DSTEP_W'(NUM_W - 1))
                    run_reg <= 1'b0;
            end
        end
    end

    // low 16 bits of |raw| << 16 are zero, so the bias drops straight in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= {raw_abs, FRAC_W'(ROUND_BIAS)};
            rem_reg <= '0;
            quo_reg <= '0;
            neg_reg <= raw[RAW_W-1];
        end
        else if (run_reg)
        begin
            num_reg <= {num_reg[NUM_W-2:0], 1'b0};
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[QUO_W-2:0], ge};
        end
    end

    assign code = neg_reg ? -$signed({1'b0, quo_reg}) : $signed({1'b0, quo_reg});
    assign done = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/vrbm_mag.sv */
// Serial sum of squares followed by a two-bits-per-step integer square root.
`default_nettype none

module vrbm_mag
    import vrbm_pkg::*;
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      start,
    input  wire logic signed [AXIS_W-1:0]  x,
    input  wire logic signed [AXIS_W-1:0]  y,
    input  wire logic signed [AXIS_W-1:0]  z,
    output logic [MAG_W-1:0]               magnitude,
    output logic                           done
);

    mag_state_t            state_reg;
    mag_state_t            state_next;
    logic [MSTEP_W-1:0]    cnt_reg;
    logic                  done_reg;

    logic [ABS_W-1:0]      ax_reg, ay_reg, az_reg;
    logic [ABS_W-1:0]      bx_reg, by_reg, bz_reg;
    logic [SUM_W-1:0]      acc_reg;
    logic [RREM_W-1:0]     rem_reg;
    logic [MAG_W-1:0]      root_reg;

    logic                  sq_en;
    logic                  rt_en;
    logic                  last_step;

    logic [ABS_W+1:0]      addend;
    logic [RREM_W+1:0]     rem_sh;
    logic [RREM_W+1:0]     trial;
    logic                  ge;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            MAG_IDLE:   if (start) state_next = MAG_SQUARE;
            MAG_SQUARE: if (cnt_reg == MSTEP_W'(SQ_STEPS - 1)) state_next = MAG_ROOT;
            MAG_ROOT:   if (cnt_reg == MSTEP_W'(RT_STEPS - 1)) state_next = MAG_IDLE;
            default:    state_next = MAG_IDLE;
        endcase
    end

    always_comb
    begin
        sq_en     = 1'b0;
        rt_en     = 1'b0;
        last_step = 1'b0;
        unique case (state_reg)
            MAG_IDLE:   ;
            MAG_SQUARE: sq_en = 1'b1;
            MAG_ROOT:
            begin
                rt_en     = 1'b1;
                last_step = (cnt_reg == MSTEP_W'(RT_STEPS - 1));
            end
            default:    ;
        endcase
    end

    // MSB-first shift-add: acc = 2*acc + sum of a_i where the multiplier bit is set
    always_comb
    begin
        addend = (ABS_W+2)'(bx_reg[ABS_W-1] ? ax_reg : '0)
               + (ABS_W+2)'(by_reg[ABS_W-1] ? ay_reg : '0)
               + (ABS_W+2)'(bz_reg[ABS_W-1] ? az_reg : '0);
        rem_sh = {rem_reg, acc_reg[SUM_W-1:SUM_W-2]};
        trial  = (RREM_W+2)'({root_reg, 2'b01});
        ge     = (rem_sh >= trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MAG_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= last_step;
            if (state_next != state_reg)
                cnt_reg <= '0;
            else if (sq_en || rt_en)
                cnt_reg <= cnt_reg + MSTEP_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (start && state_reg == MAG_IDLE)
        begin
            ax_reg   <= ABS_W'(x[AXIS_W-1] ? -x : x);
            ay_reg   <= ABS_W'(y[AXIS_W-1] ? -y : y);
            az_reg   <= ABS_W'(z[AXIS_W-1] ? -z : z);
            bx_reg   <= ABS_W'(x[AXIS_W-1] ? -x : x);
            by_reg   <= ABS_W'(y[AXIS_W-1] ? -y : y);
            bz_reg   <= ABS_W'(z[AXIS_W-1] ? -z : z);
            acc_reg  <= '0;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (sq_en)
        begin
            acc_reg <= {acc_reg[SUM_W-2:0], 1'b0} + SUM_W'(addend);
            bx_reg  <= {bx_reg[ABS_W-2:0], 1'b0};
            by_reg  <= {by_reg[ABS_W-2:0], 1'b0};
            bz_reg  <= {bz_reg[ABS_W-2:0], 1'b0};
        end
        else if (rt_en)
        begin
            acc_reg  <= {acc_reg[SUM_W-3:0], 2'b00};
            rem_reg  <= ge ? RREM_W'(rem_sh - trial) : RREM_W'(rem_sh);
            root_reg <= {root_reg[MAG_W-2:0], ge};
        end
    end

    assign magnitude = root_reg;
    assign done      = done_reg;

endmodule

`default_nettype wire

/* hw/rtl/vrbm_ring.sv */
// Entry storage of the ring: one write port, one registered read port.
`default_nettype none

module vrbm_ring
    import vrbm_pkg::*;
(
    input  wire logic     clk,
    input  wire ring_wr_t wr,
    input  wire ring_rd_t rd,
    output entry_t        rdata
);

    entry_t mem [DEPTH];
    entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
            mem[wr.addr] <= wr.data;
        if (rd.en)
            rdata_reg <= mem[rd.addr];
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

/* verif/vector_ring_buffer_magnitude_checker.sv */
`timescale 1ns / 1ps
// Checker for the ring buffer block: mirrors the ring, predicts result beats and compares them.
module vector_ring_buffer_magnitude_checker
    import vrbm_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    cfg_write,
    input  wire logic                    cfg_data,
    input  wire logic                    start,
    input  wire logic                    busy,
    input  wire logic [1:0]              command,
    input  wire logic signed [TS_W-1:0]  timestamp,
    input  wire logic signed [RAW_W-1:0] raw_x,
    input  wire logic signed [RAW_W-1:0] raw_y,
    input  wire logic signed [RAW_W-1:0] raw_z,
    input  wire logic                    strobe,
    input  wire logic                    kind,
    input  wire logic signed [TS_W-1:0]  out_timestamp,
    input  wire logic signed [AXIS_W-1:0] pos_x,
    input  wire logic signed [AXIS_W-1:0] pos_y,
    input  wire logic signed [AXIS_W-1:0] pos_z,
    input  wire logic [MAG_W-1:0]        magnitude,
    input  wire logic [OUT_CNT_W-1:0]    available_count,
    input  wire logic                    last,
    output int                           pending,
    output int                           errors
);

    localparam logic KIND_ENTRY = 1'b0;
    localparam logic KIND_COUNT = 1'b1;

    typedef struct {
        logic                     kind;
        logic signed [TS_W-1:0]   ts;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        logic signed [AXIS_W-1:0] z;
        logic [MAG_W-1:0]         mag;
        logic [OUT_CNT_W-1:0]     held;
        logic                     last;
    } beat_t;

    entry_t ring [DEPTH];
    int     wr_ptr;
    int     fill;
    logic   attached;
    beat_t  due_beats [$];

    // raw * 0.01 with 16 fraction bits, round half away from zero
    function automatic logic signed [AXIS_W-1:0] scaled_axis(input logic signed [RAW_W-1:0] raw);
        longint r;
        longint q;
        r = raw;
        q = ((r < 0 ? -r : r) * (longint'(1) << FRAC_W) + ROUND_BIAS) / SCALE_DIV;
        return AXIS_W'(r < 0 ? -q : q);
    endfunction

    function automatic logic [MAG_W-1:0] entry_magnitude(input entry_t e);
        longint ax;
        longint ay;
        longint az;
        longint sum;
        longint root;
        longint trial;
        ax = e.x;
        ay = e.y;
        az = e.z;
        sum = ax * ax + ay * ay + az * az;
        root = 0;
        // build the floor root one bit at a time, MSB first
        for (int b = MAG_W - 1; b >= 0; b--) begin
            trial = root | (longint'(1) << b);
            if (trial * trial <= sum)
                root = trial;
        end
        return MAG_W'(root);
    endfunction

    function automatic void compare_field(input string name, input logic [63:0] want,
                                          input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endfunction

    task automatic check_beat();
        beat_t want;
        if (due_beats.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual kind %0d count %0d",
                     $time, kind, available_count);
        end
        else begin
            want = due_beats.pop_front();
            compare_field("kind", want.kind, kind);
            compare_field("out_timestamp", want.ts, out_timestamp);
            compare_field("pos_x", want.x, pos_x);
            compare_field("pos_y", want.y, pos_y);
            compare_field("pos_z", want.z, pos_z);
            compare_field("magnitude", want.mag, magnitude);
            compare_field("available_count", want.held, available_count);
            compare_field("last", want.last, last);
        end
    endtask

    task automatic apply_command();
        beat_t                b;
        int                   rd;
        logic [OUT_CNT_W-1:0] held;
        held = OUT_CNT_W'(fill);
        case (command)
            CMD_PUSH:
            begin
                ring[wr_ptr].ts = timestamp;
                ring[wr_ptr].x  = scaled_axis(raw_x);
                ring[wr_ptr].y  = scaled_axis(raw_y);
                ring[wr_ptr].z  = scaled_axis(raw_z);
                wr_ptr = (wr_ptr + 1) % DEPTH;
                if (fill < DEPTH)
                    fill++;
            end
            CMD_FLUSH:
            begin
                if (attached && fill != 0)
                begin
                    rd = (wr_ptr + DEPTH - fill) % DEPTH;
                    for (int k = 0; k < fill; k++) begin
                        b.kind = KIND_ENTRY;
                        b.ts   = ring[rd].ts;
                        b.x    = ring[rd].x;
                        b.y    = ring[rd].y;
                        b.z    = ring[rd].z;
                        b.mag  = entry_magnitude(ring[rd]);
                        b.held = held;
                        b.last = (k == fill - 1);
                        due_beats.push_back(b);
                        rd = (rd + 1) % DEPTH;
                    end
                    fill = 0;
                end
            end
            CMD_COUNT:
            begin
                b.kind = KIND_COUNT;
                b.ts   = '0;
                b.x    = '0;
                b.y    = '0;
                b.z    = '0;
                b.mag  = '0;
                b.held = held;
                b.last = 1'b1;
                due_beats.push_back(b);
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr   = 0;
            fill     = 0;
            attached = 1'b0;
            due_beats.delete();
            pending  = 0;
        end
        else
        begin
            // retire the outgoing beat before queueing anything from this edge
            if (strobe)
                check_beat();
            if (cfg_write)
                attached = cfg_data;
            if (start && !busy)
                apply_command();
            pending = due_beats.size();
        end
    end

endmodule

/* verif/vector_ring_buffer_magnitude_top_tb.sv */
`timescale 1ns / 1ps
// Testbench top for the ring buffer block: clock, reset, command stimulus and verdict.
module vector_ring_buffer_magnitude_top_tb;
    import vrbm_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 80;
    localparam int DRAIN_LIMIT   = 20000;

    logic                     clk;
    logic                     rst_n;
    logic                     cfg_write;
    logic                     cfg_data;
    logic                     start;
    logic                     busy;
    logic [1:0]               command;
    logic signed [TS_W-1:0]   timestamp;
    logic signed [RAW_W-1:0]  raw_x;
    logic signed [RAW_W-1:0]  raw_y;
    logic signed [RAW_W-1:0]  raw_z;
    logic                     strobe;
    logic                     kind;
    logic signed [TS_W-1:0]   out_timestamp;
    logic signed [AXIS_W-1:0] pos_x;
    logic signed [AXIS_W-1:0] pos_y;
    logic signed [AXIS_W-1:0] pos_z;
    logic [MAG_W-1:0]         magnitude;
    logic [OUT_CNT_W-1:0]     available_count;
    logic                     last;
    int                       pending;
    int                       errors;
    bit                       gaps_on;

    vector_ring_buffer_magnitude_top u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .timestamp       (timestamp),
        .raw_x           (raw_x),
        .raw_y           (raw_y),
        .raw_z           (raw_z),
        .strobe          (strobe),
        .kind            (kind),
        .out_timestamp   (out_timestamp),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .magnitude       (magnitude),
        .available_count (available_count),
        .last            (last)
    );

    vector_ring_buffer_magnitude_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_data        (cfg_data),
        .start           (start),
        .busy            (busy),
        .command         (command),
        .timestamp       (timestamp),
        .raw_x           (raw_x),
        .raw_y           (raw_y),
        .raw_z           (raw_z),
        .strobe          (strobe),
        .kind            (kind),
        .out_timestamp   (out_timestamp),
        .pos_x           (pos_x),
        .pos_y           (pos_y),
        .pos_z           (pos_z),
        .magnitude       (magnitude),
        .available_count (available_count),
        .last            (last),
        .pending         (pending),
        .errors          (errors)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic signed [TS_W-1:0] random_stamp();
        return {$urandom, $urandom};
    endfunction

    // mostly full-range samples, some rail values and some near zero
    function automatic logic signed [RAW_W-1:0] random_raw();
        logic signed [RAW_W-1:0] v;
        case ($urandom_range(0, 4))
            0:       v = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            1:       v = RAW_W'($urandom_range(0, 600)) - 16'sd300;
            default: v = RAW_W'($urandom);
        endcase
        return v;
    endfunction

    // one command beat; start stays high into the next beat unless a gap follows
    task automatic issue(input logic [1:0] cmd, input logic signed [TS_W-1:0] ts,
                         input logic signed [RAW_W-1:0] x, input logic signed [RAW_W-1:0] y,
                         input logic signed [RAW_W-1:0] z);
        @(negedge clk);
        start     = 1'b1;
        command   = cmd;
        timestamp = ts;
        raw_x     = x;
        raw_y     = y;
        raw_z     = z;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            repeat ($urandom_range(1, 5))
            begin
                @(negedge clk);
                start     = 1'b0;
                command   = 2'($urandom);
                timestamp = random_stamp();
                raw_x     = random_raw();
                raw_y     = random_raw();
                raw_z     = random_raw();
            end
        end
    endtask

    task automatic random_item(input int push_w, input int flush_w, input int count_w);
        int         pick;
        logic [1:0] cmd;
        pick = $urandom_range(0, 99);
        if (pick < push_w)
            cmd = CMD_PUSH;
        else if (pick < push_w + flush_w)
            cmd = CMD_FLUSH;
        else if (pick < push_w + flush_w + count_w)
            cmd = CMD_COUNT;
        else
            cmd = CMD_UNUSED;
        issue(cmd, random_stamp(), random_raw(), random_raw(), random_raw());
    endtask

    // hold off until every predicted beat is out, then let a trailing push finish
    task automatic settle();
        @(negedge clk);
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
        repeat (SETTLE_CYCLES)
            @(negedge clk);
    endtask

    task automatic set_consumer(input logic attach);
        settle();
        cfg_write = 1'b1;
        cfg_data  = attach;
        @(negedge clk);
        cfg_write = 1'b0;
    endtask

    initial
    begin
        int spin;
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 1'b0;
        start     = 1'b0;
        command   = CMD_PUSH;
        timestamp = '0;
        raw_x     = '0;
        raw_y     = '0;
        raw_z     = '0;
        gaps_on   = 1'b1;
        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty ring, detached flush, rails of every field, unused code
        issue(CMD_COUNT, random_stamp(), '0, '0, '0);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);
        set_consumer(1'b1);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);
        issue(CMD_PUSH, 64'sh8000_0000_0000_0000, 16'sh8000, 16'sh7FFF, 16'sh0000);
        issue(CMD_PUSH, 64'sh7FFF_FFFF_FFFF_FFFF, 16'sh7FFF, 16'sh8000, 16'sh8000);
        issue(CMD_PUSH, 64'sh0, 16'sh8000, 16'sh8000, 16'sh8000);
        issue(CMD_PUSH, -64'sd1, 16'sd1, -16'sd1, 16'sd0);
        issue(CMD_PUSH, 64'sh5555_AAAA_5555_AAAA, 16'sh5555, 16'shAAAA, 16'sh00FF);
        issue(CMD_UNUSED, random_stamp(), random_raw(), random_raw(), random_raw());
        issue(CMD_COUNT, random_stamp(), '0, '0, '0);
        set_consumer(1'b0);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);
        issue(CMD_COUNT, random_stamp(), '0, '0, '0);
        set_consumer(1'b1);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);
        issue(CMD_COUNT, random_stamp(), '0, '0, '0);
        issue(CMD_PUSH, random_stamp(), 16'sd50, -16'sd50, 16'sd25);
        issue(CMD_PUSH, random_stamp(), 16'sd100, -16'sd100, 16'sd3);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);
        issue(CMD_PUSH, random_stamp(), -16'sd2, 16'sd7, -16'sd13);
        issue(CMD_COUNT, random_stamp(), '0, '0, '0);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);

        // mixed traffic with a consumer attached, one full drain in the middle
        repeat (55)
            random_item(60, 12, 18);
        settle();
        repeat (55)
            random_item(60, 12, 18);

        // detached: flushes leave the ring alone
        set_consumer(1'b0);
        repeat (35)
            random_item(50, 30, 15);

        // attached again: fill past DEPTH so the ring wraps, then drain it
        set_consumer(1'b1);
        repeat (75)
            random_item(90, 0, 10);
        issue(CMD_FLUSH, random_stamp(), '0, '0, '0);

        // closing stretch back to back
        gaps_on = 1'b0;
        repeat (30)
            random_item(60, 15, 20);

        @(negedge clk);
        start = 1'b0;
        spin = 0;
        while ((pending != 0 || busy) && spin < DRAIN_LIMIT)
        begin
            @(negedge clk);
            spin++;
        end
        repeat (SETTLE_CYCLES)
            @(negedge clk);
        if (pending != 0)
            $display("%0t: %0d predicted beats never arrived", $time, pending);
        if (errors == 0 && pending == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule
